// ===== hw/rtl/dwtc_pkg.sv =====
// shared types and constants for the dac weight table calibrator
package dwtc_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CODE_W    = 16;
  localparam int unsigned ROW_LEN   = 16;
  localparam int unsigned STEP_W    = 4;

  // input commands
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_CAL_EN_FIRST  = 1'b0;
  localparam logic REG_CAL_EN_SECOND = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  // result of one compare and subtract step
  typedef struct packed {
    logic              ge;
    logic [WORD_W-1:0] diff;
  } step_res_t;

endpackage

// ===== hw/rtl/dwtc_step_unit.sv =====
// shared compare and subtract unit used once per code bit
module dwtc_step_unit (
  input  logic [dwtc_pkg::WORD_W-1:0] rest_i,
  input  logic [dwtc_pkg::WORD_W-1:0] weight_i,
  output dwtc_pkg::step_res_t         res_o
);
  import dwtc_pkg::*;

  logic [WORD_W:0] sub;

  // borrow out of the subtraction is the compare
  assign sub       = {1'b0, rest_i} - {1'b0, weight_i};
  assign res_o.ge  = ~sub[WORD_W];
  assign res_o.diff = sub[WORD_W-1:0];

endmodule

// ===== hw/rtl/dac_weight_table_calibrator.sv =====
// top level: weight table, approximation sequencer, output register and register port
// load beat: written to the table at the accept edge, no result
// pass-through convert: result loaded into the output register at the accept edge
// calibrated convert: one code bit per cycle in the run state,
//   set by the single shared compare-subtract unit fed from the one table read port
// input busy during a calibrated convert; other beats one per cycle unless output stalls
// reset: sequencer idle, output empty, both enables 0; table contents undefined, no clearing
module dac_weight_table_calibrator #(
  parameter int unsigned CODE_BITS = 16,
  parameter int unsigned CHANNELS  = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic                         channel_i,
  input  logic [3:0]                   bit_index_i,
  input  logic [dwtc_pkg::WORD_W-1:0]  weight_i,
  input  logic [dwtc_pkg::WORD_W-1:0]  sample_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         out_channel_o,
  output logic [dwtc_pkg::CODE_W-1:0]  code_o,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import dwtc_pkg::*;

  // only two channels are addressable through the one-bit channel field
  localparam int unsigned ROWS   = (CHANNELS > 2) ? 2 : CHANNELS;
  localparam int unsigned DEPTH  = ROWS * ROW_LEN;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CODE_BITS - 1);

  // register file
  logic cal_en0_q, cal_en1_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_en0_q <= 1'b0;
      cal_en1_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CAL_EN_FIRST:  cal_en0_q <= pwdata[0];
        REG_CAL_EN_SECOND: cal_en1_q <= pwdata[0];
        default:           cal_en0_q <= cal_en0_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CAL_EN_FIRST:  prdata = {31'd0, cal_en0_q};
      REG_CAL_EN_SECOND: prdata = {31'd0, cal_en1_q};
      default:           prdata = 32'd0;
    endcase
  end

  // sequencer state
  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [WORD_W-1:0]   rest_q, rest_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic                ch_q, ch_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                out_ch_q, out_ch_d;
  logic [CODE_W-1:0]   out_code_q, out_code_d;
  logic                out_free;

  // input decode
  logic                in_acc;
  logic                ch_ok;
  logic                cal_on;

  // table memory
  logic [WORD_W-1:0]   mem [DEPTH];
  logic [WORD_W-1:0]   rdata_q;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic                wr_en;

  step_res_t           res;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  // stall unless idle and the output slot can take a pass-through result
  assign in_stall_o = (state_q != ST_IDLE) | ~out_free;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // a channel beyond the configured count is ignored for loads, pass-through for converts
  assign ch_ok  = (ROWS > 1) || (channel_i == 1'b0);
  assign cal_on = ch_ok & (channel_i ? cal_en1_q : cal_en0_q);

  assign wr_en   = in_acc & (command_i == CMD_LOAD) & ch_ok;
  assign wr_addr = ADDR_W'({channel_i, bit_index_i});
  // while idle prefetch the first weight; while running fetch the next one
  assign rd_addr = (state_q == ST_IDLE) ? ADDR_W'({channel_i, {STEP_W{1'b0}}})
                                        : ADDR_W'({ch_q, STEP_W'(step_q + 1'b1)});

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= weight_i;
    end
    rdata_q <= mem[rd_addr];
  end

  dwtc_step_unit u_step (
    .rest_i   (rest_q),
    .weight_i (rdata_q),
    .res_o    (res)
  );

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    rest_d      = rest_q;
    code_d      = code_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_ch_d    = out_ch_q;
    out_code_d  = out_code_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && command_i == CMD_CONVERT) begin
          if (cal_on) begin
            state_d = ST_RUN;
            step_d  = '0;
            rest_d  = sample_i;
            code_d  = '0;
            ch_d    = channel_i;
          end else begin
            // upper half of the sample straight to the output
            out_valid_d = 1'b1;
            out_ch_d    = channel_i;
            out_code_d  = sample_i[WORD_W-1:WORD_W-CODE_W];
          end
        end
      end
      ST_RUN: begin
        // one code bit per cycle, msb first
        if (res.ge) begin
          rest_d = res.diff;
          code_d = code_q | (CODE_W'(1) << (CODE_W - 1 - step_q));
        end
        step_d = STEP_W'(step_q + 1'b1);
        if (step_q == LAST_STEP) begin
          if (out_free) begin
            state_d     = ST_IDLE;
            out_valid_d = 1'b1;
            out_ch_d    = ch_q;
            out_code_d  = code_d;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        // finished code waits for the output slot
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_ch_d    = ch_q;
          out_code_d  = code_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    step_q     <= step_d;
    rest_q     <= rest_d;
    code_q     <= code_d;
    ch_q       <= ch_d;
    out_ch_q   <= out_ch_d;
    out_code_q <= out_code_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign code_o        = out_code_q;

`ifndef SYNTH
  // beats are only taken by an idle sequencer
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> state_q == ST_IDLE)
    else $error("beat accepted while sequencer busy");

  // the step counter never runs past the code width
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> step_q <= LAST_STEP)
    else $error("step counter out of range");

  // a finished approximation with a free slot lands in the output register
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q == LAST_STEP && out_free)
      |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished code not delivered");

  // holding is only entered while the output slot is occupied
  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> out_valid_q)
    else $error("hold state with empty output");
`endif

endmodule
